// ===== rtl/tlqg_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, stage payload types and the saturation helper of the
// thick line quad generator. No dependencies.
package tlqg_pkg;

   localparam int CoordW   = 24;             // Q16.8 coordinate
   localparam int DiffW    = CoordW + 1;     // exact endpoint difference
   localparam int ThickW   = 16;             // Q8.8 thickness
   localparam int SqrW     = 2 * DiffW;      // one squared difference
   localparam int LenSqW   = SqrW + 1;       // sum of two squares
   localparam int RadW     = 60;             // radicand: LenSqW + 8 fraction bits, even
   localparam int SqSteps  = RadW / 2;       // one root bit per stage
   localparam int RootW    = SqSteps;
   localparam int SqRemW   = RootW + 2;
   localparam int ProdW    = DiffW + ThickW; // |d| * thickness
   localparam int NumW     = ProdW + 3;      // times 8, plus rounding term
   localparam int DivSteps = NumW;           // one quotient bit per stage
   localparam int OffW     = NumW + 2;       // signed offset and corner sum
   localparam int CornerN  = 4;

   localparam logic [1:0] CSR_LINE_THICKNESS = 2'd0;
   localparam logic [1:0] CSR_THICK_THRESHOLD = 2'd1;
   localparam logic [ThickW-1:0] THRESHOLD_RESET = 16'd25;

   typedef struct packed {
      logic signed [CoordW-1:0] bx;
      logic signed [CoordW-1:0] by;
      logic signed [CoordW-1:0] ex;
      logic signed [CoordW-1:0] ey;
      logic                     quad;
      logic                     zero;
      logic                     neg_x;   // offset x is negative
      logic                     neg_y;   // offset y is negative
   } seg_type;

   function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [OffW-1:0] v);
      logic signed [OffW-1:0] hi;
      logic signed [OffW-1:0] lo;
      hi = OffW'(signed'({1'b0, {(CoordW-1){1'b1}}}));
      lo = -hi - OffW'(1);
      if (v > hi) return hi[CoordW-1:0];
      else if (v < lo) return lo[CoordW-1:0];
      else return v[CoordW-1:0];
   endfunction

endpackage

// ===== rtl/thick_line_quad_generator_top.sv =====
`timescale 1ns / 1ps
// Top level of the thick line quad generator: a deep pipeline of squares,
// a one-bit-per-stage square root and two one-bit-per-stage dividers. Uses tlqg_pkg.

// A segment transfer on the req_ channel produces four vertex transfers on
// the rsp_ channel when line_thickness is above thick_threshold (quad corners
// begin+v, end+v, end-v, begin-v, where v is the segment normal scaled to half
// the thickness), and two transfers (the plain endpoints) otherwise. The
// pipeline from the segment transfer to its first vertex holds three stages
// for differences, squares and sums, 30 square-root stages, one stage for
// the rounding term, 44 divider stages and the output register. A new
// segment can enter every cycle while the pipeline has room; the sustained
// rate is set by the single result port, which hands out four vertices per
// segment in quad mode and two in line mode. When the output register
// cannot hand its last vertex over, the whole pipeline holds, so nothing is
// lost or repeated. Configuration writes must only happen while the block is
// empty.
module thick_line_quad_generator_top
   import tlqg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [ThickW-1:0]        csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CoordW-1:0] req_begin_x,
   input  logic signed [CoordW-1:0] req_begin_y,
   input  logic signed [CoordW-1:0] req_end_x,
   input  logic signed [CoordW-1:0] req_end_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [CoordW-1:0] rsp_vertex_x,
   output logic signed [CoordW-1:0] rsp_vertex_y,
   output logic [1:0]               rsp_vertex_number,
   output logic                     rsp_quad_mode,
   output logic                     rsp_zero_length,
   output logic                     rsp_last_vertex
);

   // Configuration registers.
   logic [ThickW-1:0] thickness_ff;
   logic [ThickW-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thickness_ff <= '0;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_LINE_THICKNESS) thickness_ff <= csr_data;
         else if (csr_index == CSR_THICK_THRESHOLD) threshold_ff <= csr_data;
      end
   end

   // The whole pipeline moves together; it holds only when the output
   // register is full and its last vertex is not being taken.
   logic adv;
   logic out_last;
   logic hold_valid_ff;
   logic div_valid;

   // Stage 1: capture, differences and mode.
   logic                    s1_valid_ff;
   seg_type                 s1_seg_ff;
   logic signed [DiffW-1:0] s1_dx_ff;
   logic signed [DiffW-1:0] s1_dy_ff;
   logic [ThickW-1:0]       s1_t_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_seg_ff.bx    <= req_begin_x;
         s1_seg_ff.by    <= req_begin_y;
         s1_seg_ff.ex    <= req_end_x;
         s1_seg_ff.ey    <= req_end_y;
         s1_seg_ff.quad  <= thickness_ff > threshold_ff;
         s1_seg_ff.zero  <= 1'b0;
         s1_seg_ff.neg_x <= 1'b0;
         s1_seg_ff.neg_y <= 1'b0;
         s1_dx_ff <= DiffW'(req_end_x) - DiffW'(req_begin_x);
         s1_dy_ff <= DiffW'(req_end_y) - DiffW'(req_begin_y);
         s1_t_ff  <= thickness_ff;
      end
   end

   // Stage 2: squares and the thickness products. The offset x is -dy and
   // the offset y is dx, so the signs follow from those.
   logic              s2_valid_ff;
   seg_type           s2_seg_ff;
   seg_type           s2_seg_in;
   logic [SqrW-1:0]   s2_dx2_ff;
   logic [SqrW-1:0]   s2_dy2_ff;
   logic [ProdW-1:0]  s2_px_ff;
   logic [ProdW-1:0]  s2_py_ff;
   logic [DiffW-1:0]  s1_adx;
   logic [DiffW-1:0]  s1_ady;

   assign s1_adx = s1_dx_ff[DiffW-1] ? DiffW'(-s1_dx_ff) : s1_dx_ff;
   assign s1_ady = s1_dy_ff[DiffW-1] ? DiffW'(-s1_dy_ff) : s1_dy_ff;

   always_comb begin
      s2_seg_in       = s1_seg_ff;
      s2_seg_in.neg_x = !s1_dy_ff[DiffW-1] && (s1_dy_ff != '0);
      s2_seg_in.neg_y = s1_dx_ff[DiffW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_seg_ff <= s2_seg_in;
         s2_dx2_ff <= s1_adx * s1_adx;
         s2_dy2_ff <= s1_ady * s1_ady;
         s2_px_ff  <= s1_ady * s1_t_ff;
         s2_py_ff  <= s1_adx * s1_t_ff;
      end
   end

   // Stage 3: squared length, scaled by 256 into the radicand.
   logic [LenSqW-1:0] s2_l2;
   assign s2_l2 = LenSqW'(s2_dx2_ff) + LenSqW'(s2_dy2_ff);

   logic              sq_valid_ff [0:SqSteps];
   seg_type           sq_seg_ff   [0:SqSteps];
   logic [RadW-1:0]   sq_rad_ff   [0:SqSteps];
   logic [SqRemW-1:0] sq_rem_ff   [0:SqSteps];
   logic [RootW-1:0]  sq_root_ff  [0:SqSteps];
   logic [NumW-1:0]   sq_nx_ff    [0:SqSteps];
   logic [NumW-1:0]   sq_ny_ff    [0:SqSteps];
   seg_type           sq_seg_in;

   always_comb begin
      sq_seg_in      = s2_seg_ff;
      sq_seg_in.zero = s2_seg_ff.quad && (s2_l2 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) sq_valid_ff[0] <= 1'b0;
      else if (adv) sq_valid_ff[0] <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_seg_ff[0]      <= sq_seg_in;
         sq_rad_ff[0]      <= RadW'({s2_l2, 8'd0});
         sq_rem_ff[0]      <= '0;
         sq_root_ff[0]     <= '0;
         sq_nx_ff[0]       <= NumW'({s2_px_ff, 3'd0});
         sq_ny_ff[0]       <= NumW'({s2_py_ff, 3'd0});
      end
   end

   // Square root, one result bit per stage: bring down two radicand bits
   // and try to subtract 4*root+1.
   for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
      logic [SqRemW+1:0] cur;
      logic [SqRemW+1:0] trial;
      assign cur   = {sq_rem_ff[k], sq_rad_ff[k][RadW-1 -: 2]};
      assign trial = (SqRemW+2)'({sq_root_ff[k], 2'b01});

      always_ff @(posedge clock) begin
         if (reset) sq_valid_ff[k+1] <= 1'b0;
         else if (adv) sq_valid_ff[k+1] <= sq_valid_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_seg_ff[k+1] <= sq_seg_ff[k];
            sq_rad_ff[k+1] <= {sq_rad_ff[k][RadW-3:0], 2'b00};
            sq_nx_ff[k+1]  <= sq_nx_ff[k];
            sq_ny_ff[k+1]  <= sq_ny_ff[k];
            if (cur >= trial) begin
               sq_rem_ff[k+1]  <= SqRemW'(cur - trial);
               sq_root_ff[k+1] <= {sq_root_ff[k][RootW-2:0], 1'b1};
            end else begin
               sq_rem_ff[k+1]  <= SqRemW'(cur);
               sq_root_ff[k+1] <= {sq_root_ff[k][RootW-2:0], 1'b0};
            end
         end
      end
   end

   // Divider stages; entry 0 adds half the divisor for round to nearest.
   logic             dv_valid_ff [0:DivSteps];
   seg_type          dv_seg_ff   [0:DivSteps];
   logic [RootW-1:0] dv_den_ff   [0:DivSteps];
   logic [NumW-1:0]  dv_nx_ff    [0:DivSteps];
   logic [NumW-1:0]  dv_ny_ff    [0:DivSteps];
   logic [RootW-1:0] dv_rx_ff    [0:DivSteps];
   logic [RootW-1:0] dv_ry_ff    [0:DivSteps];

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else if (adv) dv_valid_ff[0] <= sq_valid_ff[SqSteps];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_seg_ff[0] <= sq_seg_ff[SqSteps];
         dv_den_ff[0] <= sq_root_ff[SqSteps];
         dv_nx_ff[0]  <= sq_nx_ff[SqSteps] + NumW'(sq_root_ff[SqSteps] >> 1);
         dv_ny_ff[0]  <= sq_ny_ff[SqSteps] + NumW'(sq_root_ff[SqSteps] >> 1);
         dv_rx_ff[0]  <= '0;
         dv_ry_ff[0]  <= '0;
      end
   end

   // Restoring division; the dividend register turns into the quotient as
   // its top bit is shifted into the remainder.
   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      logic [RootW:0] cx;
      logic [RootW:0] cy;
      logic           gx;
      logic           gy;
      assign cx = {dv_rx_ff[j], dv_nx_ff[j][NumW-1]};
      assign cy = {dv_ry_ff[j], dv_ny_ff[j][NumW-1]};
      assign gx = cx >= {1'b0, dv_den_ff[j]};
      assign gy = cy >= {1'b0, dv_den_ff[j]};

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[j+1] <= 1'b0;
         else if (adv) dv_valid_ff[j+1] <= dv_valid_ff[j];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_seg_ff[j+1] <= dv_seg_ff[j];
            dv_den_ff[j+1] <= dv_den_ff[j];
            dv_nx_ff[j+1]  <= {dv_nx_ff[j][NumW-2:0], gx};
            dv_ny_ff[j+1]  <= {dv_ny_ff[j][NumW-2:0], gy};
            dv_rx_ff[j+1]  <= gx ? RootW'(cx - {1'b0, dv_den_ff[j]}) : RootW'(cx);
            dv_ry_ff[j+1]  <= gy ? RootW'(cy - {1'b0, dv_den_ff[j]}) : RootW'(cy);
         end
      end
   end

   // Corner sums and saturation, straight into the output register.
   seg_type              fseg;
   logic signed [OffW-1:0] vx;
   logic signed [OffW-1:0] vy;
   logic signed [OffW-1:0] bx;
   logic signed [OffW-1:0] by;
   logic signed [OffW-1:0] ex;
   logic signed [OffW-1:0] ey;
   logic                   use_off;

   assign fseg      = dv_seg_ff[DivSteps];
   assign div_valid = dv_valid_ff[DivSteps];
   assign use_off   = fseg.quad && !fseg.zero;
   assign vx = !use_off ? '0 : fseg.neg_x ? -OffW'(dv_nx_ff[DivSteps]) : OffW'(dv_nx_ff[DivSteps]);
   assign vy = !use_off ? '0 : fseg.neg_y ? -OffW'(dv_ny_ff[DivSteps]) : OffW'(dv_ny_ff[DivSteps]);
   assign bx = OffW'(fseg.bx);
   assign by = OffW'(fseg.by);
   assign ex = OffW'(fseg.ex);
   assign ey = OffW'(fseg.ey);

   logic signed [CoordW-1:0] cx_ff [0:CornerN-1];
   logic signed [CoordW-1:0] cy_ff [0:CornerN-1];
   logic [1:0]               idx_ff;
   logic                     quad_ff;
   logic                     zero_ff;
   logic                     load;
   logic                     xfer;

   assign out_last = quad_ff ? (idx_ff == 2'd3) : (idx_ff == 2'd1);
   assign xfer     = hold_valid_ff && !rsp_stall;
   assign adv      = !hold_valid_ff || (xfer && out_last) || !div_valid;
   assign load     = adv && div_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (load) begin
         hold_valid_ff <= 1'b1;
         idx_ff        <= '0;
      end else if (xfer) begin
         if (out_last) hold_valid_ff <= 1'b0;
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cx_ff[0] <= sat_coord(bx + vx);
         cy_ff[0] <= sat_coord(by + vy);
         cx_ff[1] <= sat_coord(ex + vx);
         cy_ff[1] <= sat_coord(ey + vy);
         cx_ff[2] <= sat_coord(ex - vx);
         cy_ff[2] <= sat_coord(ey - vy);
         cx_ff[3] <= sat_coord(bx - vx);
         cy_ff[3] <= sat_coord(by - vy);
         quad_ff  <= fseg.quad;
         zero_ff  <= fseg.zero;
      end
   end

   assign req_stall         = !adv;
   assign rsp_valid         = hold_valid_ff;
   assign rsp_vertex_x      = cx_ff[idx_ff];
   assign rsp_vertex_y      = cy_ff[idx_ff];
   assign rsp_vertex_number = idx_ff;
   assign rsp_quad_mode     = quad_ff;
   assign rsp_zero_length   = zero_ff;
   assign rsp_last_vertex   = out_last;

endmodule
